// ===== src/three_wire_rtc_serial_master_defines.svh =====
// Assertion macros shared by the three-wire RTC serial master RTL.
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_DEFINES_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked while reset is released.
`define RTCS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rtcs assertion failed");
// Checked on every edge, reset included.
`define RTCS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rtcs assertion failed");
`else
`define RTCS_ASSERT(lbl, clk, rstn, prop)
`define RTCS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== src/rtcs_pkg.sv =====
// Shared types and constants of the three-wire RTC serial master.
package rtcs_pkg;

  localparam int unsigned HalfPeriodWidth = 16;
  localparam int unsigned ByteWidth       = 8;
  localparam int unsigned ShiftOutWidth   = 2 * ByteWidth;
  localparam int unsigned BitIndexWidth   = 4;

  localparam logic [HalfPeriodWidth-1:0] HalfPeriodReset = 16'd10;

  // Pin levels and status reported for one tick.
  typedef struct packed {
    logic                 chip_enable;
    logic                 serial_clock;
    logic                 line_out;
    logic                 line_drive;
    logic                 busy_res;
    logic                 done_res;
    logic [ByteWidth-1:0] read_data;
  } result_t;

endpackage

// ===== src/rtcs_seq.sv =====
// Phase sequencer: advances the serial waveform by one tick per transaction.
`include "three_wire_rtc_serial_master_defines.svh"

module rtcs_seq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic [rtcs_pkg::HalfPeriodWidth-1:0] half_period_i,
  input  logic                                 start_req_i,
  input  logic                                 mode_i,
  input  logic [rtcs_pkg::ByteWidth-1:0]       address_i,
  input  logic [rtcs_pkg::ByteWidth-1:0]       write_data_i,
  input  logic                                 line_in_i,
  output rtcs_pkg::result_t                    res_o
);

  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhPreCe   = 4'd1,
    PhPreClk  = 4'd2,
    PhRdGap   = 4'd3,
    PhShSet   = 4'd4,
    PhShHi    = 4'd5,
    PhShLo    = 4'd6,
    PhTailGap = 4'd7,
    PhTailHi  = 4'd8,
    PhTailLo  = 4'd9
  } phase_e;

  phase_e                                 phase_q, phase_d;
  logic [rtcs_pkg::HalfPeriodWidth-1:0]   tick_q, tick_d;
  logic [rtcs_pkg::BitIndexWidth-1:0]     bit_q, bit_d;
  logic [rtcs_pkg::ShiftOutWidth-1:0]     sout_q, sout_d;
  logic [rtcs_pkg::ByteWidth-1:0]         sin_q, sin_d;
  logic                                   rd_q, rd_d;
  logic                                   done;
  logic [rtcs_pkg::HalfPeriodWidth-1:0]   tick_inc;
  logic                                   in_data_byte;

  assign tick_inc = tick_q + 1'b1;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    sout_d  = sout_q;
    sin_d   = sin_q;
    rd_d    = rd_q;
    done    = 1'b0;
    if (phase_q == PhIdle) begin
      if (start_req_i) begin
        rd_d    = mode_i;
        sout_d  = mode_i ? {{rtcs_pkg::ByteWidth{1'b0}}, address_i}
                         : {write_data_i, address_i};
        bit_d   = '0;
        tick_d  = '0;
        phase_d = PhPreCe;
      end
    end else if (tick_inc >= half_period_i) begin
      tick_d = '0;
      case (phase_q)
        PhPreCe:   phase_d = PhPreClk;
        PhPreClk:  phase_d = rd_q ? PhRdGap : PhShSet;
        PhRdGap:   phase_d = PhShSet;
        PhShSet: begin
          // Read bits arrive LSB first, so each sample enters at the top.
          if (rd_q && bit_q[rtcs_pkg::BitIndexWidth-1]) begin
            sin_d = {line_in_i, sin_q[rtcs_pkg::ByteWidth-1:1]};
          end
          phase_d = PhShHi;
        end
        PhShHi:    phase_d = PhShLo;
        PhShLo: begin
          if (bit_q == '1) begin
            phase_d = rd_q ? PhTailGap : PhTailHi;
          end else begin
            sout_d  = sout_q >> 1;
            bit_d   = bit_q + 1'b1;
            phase_d = PhShSet;
          end
        end
        PhTailGap: phase_d = PhTailHi;
        PhTailHi:  phase_d = PhTailLo;
        default: begin
          phase_d = PhIdle;
          done    = 1'b1;
        end
      endcase
    end else begin
      tick_d = tick_inc;
    end
  end

  // The reported pins follow the phase entered on this tick.
  always_comb begin
    res_o           = '0;
    res_o.done_res  = done;
    res_o.read_data = sin_d;
    in_data_byte    = rd_d && bit_d[rtcs_pkg::BitIndexWidth-1];
    if (phase_d != PhIdle) begin
      res_o.busy_res     = 1'b1;
      res_o.chip_enable  = phase_d inside {[PhRdGap:PhTailLo]};
      res_o.serial_clock = (phase_d == PhShHi) || (phase_d == PhTailHi);
      if (phase_d inside {[PhShSet:PhShLo]}) begin
        res_o.line_drive = !in_data_byte;
      end else if (phase_d inside {PhTailHi, PhTailLo}) begin
        res_o.line_drive = !rd_d;
      end
      res_o.line_out = res_o.line_drive && sout_d[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      tick_q  <= '0;
      bit_q   <= '0;
      sout_q  <= '0;
      sin_q   <= '0;
      rd_q    <= 1'b0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      sout_q  <= sout_d;
      sin_q   <= sin_d;
      rd_q    <= rd_d;
    end
  end

  `RTCS_ASSERT(a_idle_tick_zero, clk_i, rst_ni, (phase_q == PhIdle) |-> (tick_q == '0))
  `RTCS_ASSERT(a_done_to_idle, clk_i, rst_ni, (adv_i && done) |=> (phase_q == PhIdle))

endmodule

// ===== src/rtcs_obuf.sv =====
// Two-entry result buffer that decouples the tick input from the result output.
`include "three_wire_rtc_serial_master_defines.svh"

module rtcs_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_stall_o,
  input  rtcs_pkg::result_t push_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rtcs_pkg::result_t out_data_o
);

  rtcs_pkg::result_t main_q, skid_q;
  logic              main_vld_q, skid_vld_q;
  logic              push, pop;

  assign push_stall_o = skid_vld_q;
  assign push         = push_valid_i && !skid_vld_q;
  assign pop          = main_vld_q && !out_stall_i;
  assign out_valid_o  = main_vld_q;
  assign out_data_o   = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (main_vld_q && !pop) begin
        skid_vld_q <= 1'b1;
      end
      main_vld_q <= 1'b1;
    end else if (pop) begin
      main_vld_q <= 1'b0;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push) begin
      if (main_vld_q && !pop) begin
        skid_q <= push_data_i;
      end else begin
        main_q <= push_data_i;
      end
    end
  end

  `RTCS_ASSERT(a_skid_needs_main, clk_i, rst_ni, !skid_vld_q || main_vld_q)
  `RTCS_ASSERT(a_skid_fills_on_stall, clk_i, rst_ni, $rose(skid_vld_q) |-> $past(main_vld_q && out_stall_i))

endmodule

// ===== src/three_wire_rtc_serial_master.sv =====
// Top level of the three-wire RTC serial master.
// Each accepted input transaction is one timing tick; the block moves the chip enable,
// serial clock and data pins of a single-byte register write or read, one waveform phase
// lasting half_period ticks (one tick if it is zero), and returns one result transaction
// per tick with the pin levels, busy and done flags and the read byte. A tick is accepted
// in every cycle: the phase sequencer updates its state and computes the result in the
// same cycle, and the result is registered into a two-entry output buffer that drives the
// output, so input is stalled only once two results wait to be taken.
// half_period is written through the configuration port, which is always ready; write it
// only while no transaction is in progress.
module three_wire_rtc_serial_master (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rtcs_pkg::HalfPeriodWidth-1:0] cfg_half_period_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 start_req_i,
  input  logic                                 mode_i,
  input  logic [rtcs_pkg::ByteWidth-1:0]       address_i,
  input  logic [rtcs_pkg::ByteWidth-1:0]       write_data_i,
  input  logic                                 line_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 chip_enable_o,
  output logic                                 serial_clock_o,
  output logic                                 line_out_o,
  output logic                                 line_drive_o,
  output logic                                 busy_res_o,
  output logic                                 done_res_o,
  output logic [rtcs_pkg::ByteWidth-1:0]       read_data_o
);

  logic [rtcs_pkg::HalfPeriodWidth-1:0] half_period_q;
  logic                                 adv;
  rtcs_pkg::result_t                    tick_res, out_res;

  assign cfg_ready_o = 1'b1;
  assign adv         = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= rtcs_pkg::HalfPeriodReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      half_period_q <= cfg_half_period_i;
    end
  end

  rtcs_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .half_period_i (half_period_q),
    .start_req_i   (start_req_i),
    .mode_i        (mode_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .line_in_i     (line_in_i),
    .res_o         (tick_res)
  );

  rtcs_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_data_i  (tick_res),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_res)
  );

  assign chip_enable_o  = out_res.chip_enable;
  assign serial_clock_o = out_res.serial_clock;
  assign line_out_o     = out_res.line_out;
  assign line_drive_o   = out_res.line_drive;
  assign busy_res_o     = out_res.busy_res;
  assign done_res_o     = out_res.done_res;
  assign read_data_o    = out_res.read_data;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the three-wire RTC serial master.
module tb;

  // Waveform phases of one serial transaction, in sequencer order.
  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_CE_LOW,
    SEQ_CLK_LOW,
    SEQ_READ_GAP,
    SEQ_BIT_SET,
    SEQ_BIT_HIGH,
    SEQ_BIT_LOW,
    SEQ_END_GAP,
    SEQ_END_HIGH,
    SEQ_END_LOW
  } seq_phase_e;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HEAVY,
    STALL_ALTERNATE
  } stall_mode_e;

  // Ways of driving line_in during a transaction.
  typedef enum int {
    LINE_RANDOM,
    LINE_HIGH,
    LINE_LOW
  } line_style_e;

  // Requests made while a transaction runs.
  typedef enum int {
    REQ_NEVER,
    REQ_ALWAYS,
    REQ_RANDOM
  } busy_req_e;

  localparam logic        XFER_WRITE   = 1'b0;
  localparam logic        XFER_READ    = 1'b1;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned RANDOM_TICKS = 250;

  logic                                 clk_i             = 1'b0;
  logic                                 rst_ni            = 1'b0;
  logic                                 cfg_valid_i       = 1'b0;
  logic                                 cfg_ready_o;
  logic [rtcs_pkg::HalfPeriodWidth-1:0] cfg_half_period_i = '0;
  logic                                 in_valid_i        = 1'b0;
  logic                                 in_stall_o;
  logic                                 start_req_i       = 1'b0;
  logic                                 mode_i            = 1'b0;
  logic [rtcs_pkg::ByteWidth-1:0]       address_i         = '0;
  logic [rtcs_pkg::ByteWidth-1:0]       write_data_i      = '0;
  logic                                 line_in_i         = 1'b0;
  logic                                 out_valid_o;
  logic                                 out_stall_i       = 1'b0;
  logic                                 chip_enable_o;
  logic                                 serial_clock_o;
  logic                                 line_out_o;
  logic                                 line_drive_o;
  logic                                 busy_res_o;
  logic                                 done_res_o;
  logic [rtcs_pkg::ByteWidth-1:0]       read_data_o;

  // Predicted sequencer state.
  logic [rtcs_pkg::HalfPeriodWidth-1:0] half_period_cfg = rtcs_pkg::HalfPeriodReset;
  seq_phase_e                           seq_phase       = SEQ_IDLE;
  logic [rtcs_pkg::HalfPeriodWidth-1:0] phase_ticks     = '0;
  logic [rtcs_pkg::BitIndexWidth-1:0]   bit_pos         = '0;
  logic [rtcs_pkg::ShiftOutWidth-1:0]   out_shift       = '0;
  logic [rtcs_pkg::ByteWidth-1:0]       in_shift        = '0;
  logic                                 read_xfer       = 1'b0;

  rtcs_pkg::result_t expected_ticks[$];
  int unsigned       mismatch_count = 0;
  int unsigned       checked_ticks  = 0;
  int unsigned       busy_ticks     = 0;
  int unsigned       write_count    = 0;
  int unsigned       read_count     = 0;
  int unsigned       setting_count  = 0;
  int unsigned       burst_left     = 0;
  int unsigned       idle_cycles    = 0;
  logic [8:0]        stall_cycle    = '0;

  three_wire_rtc_serial_master dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_half_period_i (cfg_half_period_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .start_req_i       (start_req_i),
    .mode_i            (mode_i),
    .address_i         (address_i),
    .write_data_i      (write_data_i),
    .line_in_i         (line_in_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .chip_enable_o     (chip_enable_o),
    .serial_clock_o    (serial_clock_o),
    .line_out_o        (line_out_o),
    .line_drive_o      (line_drive_o),
    .busy_res_o        (busy_res_o),
    .done_res_o        (done_res_o),
    .read_data_o       (read_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advances the predicted sequencer by one tick and returns the pin levels of that tick.
  function automatic rtcs_pkg::result_t step_sequencer(
      input logic start, input logic mode,
      input logic [rtcs_pkg::ByteWidth-1:0] addr,
      input logic [rtcs_pkg::ByteWidth-1:0] wdat,
      input logic line);
    rtcs_pkg::result_t res;
    res = '0;
    if (seq_phase == SEQ_IDLE) begin
      if (start) begin
        read_xfer   = mode;
        out_shift   = mode ? {8'h00, addr} : {wdat, addr};
        bit_pos     = '0;
        phase_ticks = '0;
        seq_phase   = SEQ_CE_LOW;
      end
    end else begin
      phase_ticks = phase_ticks + 16'd1;
      // A zero setting ends every phase after one tick, just like a setting of one.
      if (phase_ticks >= half_period_cfg) begin
        phase_ticks = '0;
        case (seq_phase)
          SEQ_CE_LOW:   seq_phase = SEQ_CLK_LOW;
          SEQ_CLK_LOW:  seq_phase = read_xfer ? SEQ_READ_GAP : SEQ_BIT_SET;
          SEQ_READ_GAP: seq_phase = SEQ_BIT_SET;
          SEQ_BIT_SET: begin
            // Read bits are taken at the end of the wait, before the clock rises.
            if (read_xfer && bit_pos >= 4'd8) in_shift = {line, in_shift[7:1]};
            seq_phase = SEQ_BIT_HIGH;
          end
          SEQ_BIT_HIGH: seq_phase = SEQ_BIT_LOW;
          SEQ_BIT_LOW: begin
            if (bit_pos == 4'd15) begin
              seq_phase = read_xfer ? SEQ_END_GAP : SEQ_END_HIGH;
            end else begin
              out_shift = out_shift >> 1;
              bit_pos   = bit_pos + 4'd1;
              seq_phase = SEQ_BIT_SET;
            end
          end
          SEQ_END_GAP:  seq_phase = SEQ_END_HIGH;
          SEQ_END_HIGH: seq_phase = SEQ_END_LOW;
          default: begin
            seq_phase    = SEQ_IDLE;
            res.done_res = 1'b1;
          end
        endcase
      end
    end
    if (seq_phase != SEQ_IDLE) begin
      res.busy_res     = 1'b1;
      res.chip_enable  = (seq_phase >= SEQ_READ_GAP);
      res.serial_clock = (seq_phase == SEQ_BIT_HIGH) || (seq_phase == SEQ_END_HIGH);
      if (seq_phase >= SEQ_BIT_SET && seq_phase <= SEQ_BIT_LOW) begin
        res.line_drive = !(read_xfer && bit_pos >= 4'd8);
      end else if (seq_phase == SEQ_END_HIGH || seq_phase == SEQ_END_LOW) begin
        res.line_drive = !read_xfer;
      end
      // The write tail pulse keeps the last data bit on the line.
      res.line_out = res.line_drive & out_shift[0];
    end
    res.read_data = in_shift;
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  // Sends one tick; the sender runs in bursts with random gaps in between.
  task automatic send_tick(input logic start, input logic mode,
                           input logic [rtcs_pkg::ByteWidth-1:0] addr,
                           input logic [rtcs_pkg::ByteWidth-1:0] wdat, input logic line);
    rtcs_pkg::result_t res;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    start_req_i  <= start;
    mode_i       <= mode;
    address_i    <= addr;
    write_data_i <= wdat;
    line_in_i    <= line;
    do @(posedge clk_i); while (in_stall_o);
    if (seq_phase != SEQ_IDLE || start) busy_ticks++;
    res = step_sequencer(start, mode, addr, wdat, line);
    expected_ticks.push_back(res);
  endtask

  // Starts one transaction and keeps ticking until the done tick has been sent.
  task automatic run_transfer(input logic mode, input logic [rtcs_pkg::ByteWidth-1:0] addr,
                              input logic [rtcs_pkg::ByteWidth-1:0] wdat,
                              input line_style_e style, input busy_req_e busy_req);
    logic line;
    logic req;
    line = (style == LINE_HIGH) ? 1'b1 : (style == LINE_LOW) ? 1'b0 : 1'($urandom_range(0, 1));
    send_tick(1'b1, mode, addr, wdat, line);
    if (mode == XFER_READ) read_count++;
    else write_count++;
    do begin
      line = (style == LINE_HIGH) ? 1'b1 :
             (style == LINE_LOW) ? 1'b0 : 1'($urandom_range(0, 1));
      req  = (busy_req == REQ_ALWAYS) ? 1'b1 :
             (busy_req == REQ_NEVER) ? 1'b0 : 1'($urandom_range(0, 1));
      send_tick(req, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), line);
    end while (seq_phase != SEQ_IDLE);
  endtask

  task automatic idle_ticks(input int unsigned count);
    repeat (count) begin
      send_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // The phase length is only changed with the sequencer idle and every result taken.
  task automatic set_half_period(input logic [rtcs_pkg::HalfPeriodWidth-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_half_period_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i     <= 1'b0;
    half_period_cfg  = value;
    setting_count++;
  endtask

  task automatic test_reset_state();
    idle_ticks(6);
    run_transfer(XFER_WRITE, 8'h8E, 8'h00, LINE_RANDOM, REQ_NEVER);
  endtask

  task automatic test_write_extremes();
    set_half_period(16'd1);
    run_transfer(XFER_WRITE, 8'h00, 8'hFF, LINE_RANDOM, REQ_NEVER);
    run_transfer(XFER_WRITE, 8'hFF, 8'h00, LINE_RANDOM, REQ_ALWAYS);
    run_transfer(XFER_WRITE, 8'hA5, 8'h5A, LINE_RANDOM, REQ_RANDOM);
    run_transfer(XFER_WRITE, 8'h01, 8'h80, LINE_RANDOM, REQ_NEVER);
  endtask

  task automatic test_read_extremes();
    set_half_period(16'd2);
    run_transfer(XFER_READ, 8'hFF, 8'hFF, LINE_HIGH, REQ_NEVER);
    run_transfer(XFER_READ, 8'h00, 8'h00, LINE_LOW, REQ_ALWAYS);
    run_transfer(XFER_READ, 8'h81, 8'h3C, LINE_RANDOM, REQ_RANDOM);
    // A write in between must leave the read byte alone.
    run_transfer(XFER_WRITE, 8'h80, 8'hC3, LINE_RANDOM, REQ_NEVER);
    run_transfer(XFER_READ, 8'h7E, 8'h00, LINE_HIGH, REQ_NEVER);
  endtask

  task automatic test_zero_half_period();
    set_half_period(16'd0);
    run_transfer(XFER_WRITE, 8'h5A, 8'hA5, LINE_RANDOM, REQ_RANDOM);
    run_transfer(XFER_READ, 8'hC1, 8'h00, LINE_RANDOM, REQ_ALWAYS);
  endtask

  task automatic test_slow_phase();
    // The longest setting is only held over idle ticks, a transfer would take millions.
    set_half_period(16'hFFFF);
    idle_ticks(10);
  endtask

  task automatic test_random_transfers();
    int unsigned       goal;
    int unsigned       pick;
    logic [15:0]       hp;
    logic              mode;
    goal = busy_ticks + RANDOM_TICKS;
    while (busy_ticks < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) hp = 16'($urandom_range(0, 2));
      else if (pick < 9) hp = 16'($urandom_range(3, 6));
      else hp = 16'($urandom_range(7, 20));
      set_half_period(hp);
      repeat ($urandom_range(2, 6)) begin
        if (busy_ticks < goal) begin
          mode = 1'($urandom_range(0, 1));
          run_transfer(mode, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       ($urandom_range(0, 5) == 0) ? LINE_HIGH : LINE_RANDOM,
                       busy_req_e'($urandom_range(0, 2)));
          idle_ticks($urandom_range(0, 3));
        end
      end
    end
  endtask

  // The receiver cycles through its own stall patterns, including stretches with none.
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 9'd1;
    case (stall_mode_e'(stall_cycle[8:7]))
      STALL_NONE:   out_stall_i <= 1'b0;
      STALL_RANDOM: out_stall_i <= ($urandom_range(0, 2) == 0);
      STALL_HEAVY:  out_stall_i <= (stall_cycle[2:0] < 3'd5);
      default:      out_stall_i <= stall_cycle[0];
    endcase
  end

  // Compares every result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_ticks.size() == 0) begin
        $error("result transaction arrived with nothing expected");
        mismatch_count++;
      end else begin
        check_field("chip_enable", 32'(expected_ticks[0].chip_enable), 32'(chip_enable_o));
        check_field("serial_clock", 32'(expected_ticks[0].serial_clock),
                    32'(serial_clock_o));
        check_field("line_out", 32'(expected_ticks[0].line_out), 32'(line_out_o));
        check_field("line_drive", 32'(expected_ticks[0].line_drive), 32'(line_drive_o));
        check_field("busy_res", 32'(expected_ticks[0].busy_res), 32'(busy_res_o));
        check_field("done_res", 32'(expected_ticks[0].done_res), 32'(done_res_o));
        check_field("read_data", 32'(expected_ticks[0].read_data), 32'(read_data_o));
        void'(expected_ticks.pop_front());
        checked_ticks++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_write_extremes();
    test_read_extremes();
    test_zero_half_period();
    test_slow_phase();
    test_random_transfers();
    in_valid_i <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("tb: %0d ticks checked, %0d of them inside transfers", checked_ticks, busy_ticks);
    $display("tb: %0d writes and %0d reads over %0d phase length settings",
             write_count, read_count, setting_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/rtcs_pkg.sv
src/rtcs_seq.sv
src/rtcs_obuf.sv
src/three_wire_rtc_serial_master.sv
verif/tb.sv
